// ===== design/xbd_pkg.sv =====
// ----------------------------------------------------------------------------
// xbd_pkg
// Shared types, class codes and decode helpers for the 8086 byte decoder.
// ----------------------------------------------------------------------------
package xbd_pkg;

    localparam logic [2:0] CLS_MOV_RM  = 3'd0;
    localparam logic [2:0] CLS_MOV_IMM = 3'd1;
    localparam logic [2:0] CLS_ALU_RM  = 3'd2;
    localparam logic [2:0] CLS_ALU_IMM = 3'd3;
    localparam logic [2:0] CLS_ALU_ACC = 3'd4;
    localparam logic [2:0] CLS_JCC     = 3'd5;
    localparam logic [2:0] CLS_LOOP    = 3'd6;
    localparam logic [2:0] CLS_NONE    = 3'd7;

    localparam logic [7:0] MASK_FC     = 8'b11111100;
    localparam logic [7:0] MASK_F0     = 8'b11110000;
    localparam logic [7:0] MASK_C4     = 8'b11000100;
    localparam logic [7:0] PAT_MOV_RM  = 8'b10001000;
    localparam logic [7:0] PAT_MOV_IMM = 8'b10110000;
    localparam logic [7:0] PAT_ALU_RM  = 8'b00000000;
    localparam logic [7:0] PAT_ALU_IMM = 8'b10000000;
    localparam logic [7:0] PAT_ALU_ACC = 8'b00000100;
    localparam logic [7:0] PAT_JCC     = 8'b01110000;
    localparam logic [7:0] PAT_LOOP    = 8'b11100000;

    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;
    localparam logic [2:0] RM_DIRECT   = 3'b110;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_OPCODE  = 6'b000001,
        PH_MODRM   = 6'b000010,
        PH_DISP_LO = 6'b000100,
        PH_DISP_HI = 6'b001000,
        PH_IMM_LO  = 6'b010000,
        PH_IMM_HI  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
    } raw_insn_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2:0] class_of(input logic [7:0] b);
        logic [2:0] c;
        if ((b & MASK_FC) == PAT_MOV_RM)       c = CLS_MOV_RM;
        else if ((b & MASK_F0) == PAT_MOV_IMM) c = CLS_MOV_IMM;
        else if ((b & MASK_C4) == PAT_ALU_RM)  c = CLS_ALU_RM;
        else if ((b & MASK_FC) == PAT_ALU_IMM) c = CLS_ALU_IMM;
        else if ((b & MASK_C4) == PAT_ALU_ACC) c = CLS_ALU_ACC;
        else if ((b & MASK_F0) == PAT_JCC)     c = CLS_JCC;
        else if ((b & MASK_FC) == PAT_LOOP)    c = CLS_LOOP;
        else                                   c = CLS_NONE;
        return c;
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] m);
        logic [1:0] n;
        case (m[7:6])
            MOD_DISP8:   n = 2'd1;
            MOD_DISP16:  n = 2'd2;
            MOD_NO_DISP: n = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            default:     n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] imm_bytes(input logic [7:0] b);
        logic [1:0] n;
        case (class_of(b))
            CLS_MOV_IMM: n = b[3] ? 2'd2 : 2'd1;
            CLS_ALU_IMM: n = (!b[1] && b[0]) ? 2'd2 : 2'd1;
            CLS_ALU_ACC: n = b[0] ? 2'd2 : 2'd1;
            CLS_JCC:     n = 2'd1;
            CLS_LOOP:    n = 2'd1;
            default:     n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

endpackage

// ===== design/xbd_byte_if.sv =====
// ----------------------------------------------------------------------------
// xbd_byte_if
// Valid/ready channel carrying one code byte per transfer.
// ----------------------------------------------------------------------------
interface xbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

// ===== design/xbd_insn_if.sv =====
// ----------------------------------------------------------------------------
// xbd_insn_if
// Valid/ready channel carrying one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface xbd_insn_if;
    logic               valid;
    logic               ready;
    logic [2:0]         insn_class;
    logic [3:0]         operation;
    logic               dir_flag;
    logic               wide;
    logic [1:0]         addr_mode;
    logic [2:0]         reg_sel;
    logic [2:0]         rm_sel;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;

    modport source (
        output valid, output insn_class, output operation, output dir_flag,
        output wide, output addr_mode, output reg_sel, output rm_sel,
        output displacement, output immediate, input ready
    );
    modport sink (
        input valid, input insn_class, input operation, input dir_flag,
        input wide, input addr_mode, input reg_sel, input rm_sel,
        input displacement, input immediate, output ready
    );
endinterface

// ===== design/xbd_front.sv =====
// ----------------------------------------------------------------------------
// xbd_front
// Byte assembler: classifies opcode bytes, gathers ModRM, displacement and
// immediate bytes, and pushes each completed instruction into the queue.
// ----------------------------------------------------------------------------
module xbd_front
    import xbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    xbd_byte_if.sink   code,
    input  q_status_t  q_stat,
    output logic       push_valid,
    output raw_insn_t  push_rec
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [7:0]  imm_lo_reg, imm_lo_next;
    logic        take;
    logic        done;
    logic [15:0] imm_val;

    assign code.ready = !q_stat.full;
    assign take       = code.valid && code.ready;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        disp_next   = disp_reg;
        imm_lo_next = imm_lo_reg;
        done        = 1'b0;
        imm_val     = 16'd0;
        if (take)
        begin
            case (phase_reg)
                PH_MODRM:
                begin
                    modrm_next = code.code_byte;
                    disp_next  = 16'd0;
                    if (disp_bytes(code.code_byte) != 2'd0)
                        phase_next = PH_DISP_LO;
                    else if (imm_bytes(opcode_reg) == 2'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_IMM_LO;
                end
                PH_DISP_LO:
                begin
                    if (disp_bytes(modrm_reg) == 2'd1)
                    begin
                        disp_next = sext8(code.code_byte);
                        if (imm_bytes(opcode_reg) == 2'd0)
                            done = 1'b1;
                        else
                            phase_next = PH_IMM_LO;
                    end
                    else
                    begin
                        disp_next  = {8'd0, code.code_byte};
                        phase_next = PH_DISP_HI;
                    end
                end
                PH_DISP_HI:
                begin
                    disp_next = {code.code_byte, disp_reg[7:0]};
                    if (imm_bytes(opcode_reg) == 2'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_IMM_LO;
                end
                PH_IMM_LO:
                begin
                    if (imm_bytes(opcode_reg) == 2'd2)
                    begin
                        imm_lo_next = code.code_byte;
                        phase_next  = PH_IMM_HI;
                    end
                    else
                    begin
                        imm_val = sext8(code.code_byte);
                        done    = 1'b1;
                    end
                end
                PH_IMM_HI:
                begin
                    imm_val = {code.code_byte, imm_lo_reg};
                    done    = 1'b1;
                end
                default:
                begin
                    phase_next = PH_OPCODE;
                    if (class_of(code.code_byte) != CLS_NONE)
                    begin
                        opcode_next = code.code_byte;
                        modrm_next  = 8'd0;
                        disp_next   = 16'd0;
                        imm_lo_next = 8'd0;
                        if (class_of(code.code_byte) inside
                            {CLS_MOV_RM, CLS_ALU_RM, CLS_ALU_IMM})
                            phase_next = PH_MODRM;
                        else
                            phase_next = PH_IMM_LO;
                    end
                end
            endcase
            if (done)
                phase_next = PH_OPCODE;
        end
    end

    assign push_valid      = done;
    assign push_rec.opcode = opcode_reg;
    assign push_rec.modrm  = modrm_next;
    assign push_rec.disp   = disp_next;
    assign push_rec.imm    = imm_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            opcode_reg <= 8'd0;
            modrm_reg  <= 8'd0;
            disp_reg   <= 16'd0;
            imm_lo_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            disp_reg   <= disp_next;
            imm_lo_reg <= imm_lo_next;
        end
    end

endmodule

// ===== design/xbd_queue.sv =====
// ----------------------------------------------------------------------------
// xbd_queue
// Short FIFO of assembled instructions between the front and back parts.
// ----------------------------------------------------------------------------
module xbd_queue
    import xbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  raw_insn_t  push_rec,
    input  logic       pop,
    output q_status_t  q_stat,
    output raw_insn_t  head_rec
);

    raw_insn_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push_valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_rec     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

// ===== design/xbd_back.sv =====
// ----------------------------------------------------------------------------
// xbd_back
// Field extraction: turns an assembled instruction into decoded fields and
// holds them in the output register until the transfer completes.
// ----------------------------------------------------------------------------
module xbd_back
    import xbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_stat,
    input  raw_insn_t  head_rec,
    output logic       pop,
    xbd_insn_if.source insn
);

    logic        valid_reg, valid_next;
    logic [2:0]  cls_reg, cls_next;
    logic [3:0]  op_reg, op_next;
    logic        dir_reg, dir_next;
    logic        wide_reg, wide_next;
    logic [1:0]  mod_reg, mod_next;
    logic [2:0]  reg_reg, reg_next;
    logic [2:0]  rm_reg, rm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [7:0]  b;
    logic [7:0]  m;

    assign pop = !q_stat.empty && (!valid_reg || insn.ready);
    assign b   = head_rec.opcode;
    assign m   = head_rec.modrm;

    always_comb
    begin
        cls_next  = class_of(b);
        op_next   = 4'd0;
        dir_next  = 1'b0;
        wide_next = 1'b0;
        mod_next  = 2'd0;
        reg_next  = 3'd0;
        rm_next   = 3'd0;
        disp_next = 16'd0;
        imm_next  = head_rec.imm;
        case (cls_next)
            CLS_MOV_RM, CLS_ALU_RM, CLS_ALU_IMM:
            begin
                mod_next  = m[7:6];
                reg_next  = m[5:3];
                rm_next   = m[2:0];
                disp_next = head_rec.disp;
                dir_next  = b[1];
                wide_next = b[0];
                if (cls_next == CLS_ALU_RM)
                    op_next = {1'b0, b[5:3]};
                if (cls_next == CLS_ALU_IMM)
                    op_next = {1'b0, m[5:3]};
                if (cls_next != CLS_ALU_IMM)
                    imm_next = 16'd0;
            end
            CLS_MOV_IMM:
            begin
                dir_next  = 1'b1;
                wide_next = b[3];
                mod_next  = MOD_REG;
                reg_next  = b[2:0];
            end
            CLS_ALU_ACC:
            begin
                op_next   = {1'b0, b[5:3]};
                dir_next  = 1'b1;
                wide_next = b[0];
                mod_next  = MOD_REG;
            end
            CLS_JCC:
                op_next = b[3:0];
            default:
                op_next = {2'b00, b[1:0]};
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (insn.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cls_reg  <= cls_next;
            op_reg   <= op_next;
            dir_reg  <= dir_next;
            wide_reg <= wide_next;
            mod_reg  <= mod_next;
            reg_reg  <= reg_next;
            rm_reg   <= rm_next;
            disp_reg <= disp_next;
            imm_reg  <= imm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign insn.valid        = valid_reg;
    assign insn.insn_class   = cls_reg;
    assign insn.operation    = op_reg;
    assign insn.dir_flag     = dir_reg;
    assign insn.wide         = wide_reg;
    assign insn.addr_mode    = mod_reg;
    assign insn.reg_sel      = reg_reg;
    assign insn.rm_sel       = rm_reg;
    assign insn.displacement = disp_reg;
    assign insn.immediate    = imm_reg;

endmodule

// ===== design/x86_16bit_instruction_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// x86_16bit_instruction_byte_decoder
// Decodes an 8086 machine-code byte stream into instruction fields.
// ----------------------------------------------------------------------------
// The code channel takes one byte per transfer and the insn channel gives one
// decoded instruction per transfer, both valid/ready.
// Bytes are taken at one per cycle; the byte assembler in the front part
// advances a small phase machine once per byte and waits on the back part
// only when the queue is full.
// A decoded instruction is first written into the two-entry queue and then
// loaded into the output register once that register is free or its
// instruction is being accepted.
// An unrecognized opcode byte is dropped and produces no output.
// When the receiver stalls, the output register holds its instruction and
// the queue fills; code bytes are still taken until the queue is full, and
// ready drops only then.
// Reset clears the phase machine, the queue and the output valid, so the
// next byte is treated as an opcode.
// ----------------------------------------------------------------------------
module x86_16bit_instruction_byte_decoder
    import xbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    xbd_byte_if.sink   code,
    xbd_insn_if.source insn
);

    q_status_t q_stat;
    logic      push_valid;
    raw_insn_t push_rec;
    logic      pop;
    raw_insn_t head_rec;

    xbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code       (code),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    xbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .pop        (pop),
        .q_stat     (q_stat),
        .head_rec   (head_rec)
    );

    xbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_rec (head_rec),
        .pop      (pop),
        .insn     (insn)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> !push_valid)
        else $error("instruction pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
                     insn.valid |-> insn.insn_class != CLS_NONE)
        else $error("output carries an unrecognized class");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (!q_stat.empty && !insn.valid) |=> insn.valid)
        else $error("queued instruction not moved to the output register");

endmodule
